// File: sv/cfsf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the coupled field stencil core.
// No dependencies; imported by every module of the block.
package cfsf_pkg;

    localparam int DEF_GRID_N    = 64;
    localparam int DEF_FRAC_BITS = 24;

    localparam int SITE_W = 18;
    localparam int VAL_W  = 32;
    localparam int CFG_AW = 3;
    localparam int WORD_W = 6 * VAL_W;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [CFG_AW-1:0] CFG_MASS_SQ    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_TRIPLE_MU  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TRIPLE_KAP = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PAIR_GAIN  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CROSS_GAIN = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_INV_DX2    = 3'd5;

    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [VAL_W-1:0] q_t;

    // saturate a wide signed value to 32 bits
    function automatic q_t clip32(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sd2147483647)
            r = Q_MAX;
        else if (v < -64'sd2147483648)
            r = Q_MIN;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

endpackage

// File: sv/cfsf_field_mem.sv
`timescale 1ns / 1ps
// Site store: one word per site holding the three S and three B components.
// One write port, one read port with registered read data. Uses cfsf_pkg.
module cfsf_field_mem #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [cfsf_pkg::WORD_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [cfsf_pkg::WORD_W-1:0] rd_data
);
    import cfsf_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/cfsf_div.sv
`timescale 1ns / 1ps
// Bit-serial signed fixed-point divider: (num << FRAC_BITS) / den, truncated, saturated.
// One quotient bit per cycle. Uses cfsf_pkg.
module cfsf_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cfsf_pkg::q_t     num,
    input  cfsf_pkg::q_t     den,
    output logic             done,
    output cfsf_pkg::q_t     quo
);
    import cfsf_pkg::*;

    localparam int NW = VAL_W + FRAC_BITS;
    localparam int CW = $clog2(NW);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] nmag_reg;
    logic [31:0]   dmag_reg;
    logic [32:0]   rem_reg;
    logic          neg_reg;
    logic          zden_reg;
    logic          npos_reg;
    logic          nneg_reg;

    logic [32:0] num_abs;
    logic [32:0] den_abs;
    logic [32:0] trial;
    logic        fits;

    assign num_abs = num[VAL_W-1] ? (33'd0 - {1'b1, num}) : {1'b0, num};
    assign den_abs = den[VAL_W-1] ? (33'd0 - {1'b1, den}) : {1'b0, den};
    assign trial   = {rem_reg[31:0], nmag_reg[NW-1]};
    assign fits    = trial >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nmag_reg <= {num_abs[31:0], {FRAC_BITS{1'b0}}};
            dmag_reg <= den_abs[31:0];
            rem_reg  <= '0;
            neg_reg  <= num[VAL_W-1] ^ den[VAL_W-1];
            zden_reg <= den == '0;
            npos_reg <= !num[VAL_W-1] && (num != '0);
            nneg_reg <= num[VAL_W-1];
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? (trial - {1'b0, dmag_reg}) : trial;
            nmag_reg <= {nmag_reg[NW-2:0], fits};
        end
    end

    always_comb
    begin
        quo = '0;
        if (zden_reg)
        begin
            if (npos_reg)
                quo = Q_MAX;
            else if (nneg_reg)
                quo = Q_MIN;
        end
        else if (!neg_reg)
        begin
            quo = (nmag_reg > NW'(64'h7fff_ffff)) ? Q_MAX : nmag_reg[VAL_W-1:0];
        end
        else
        begin
            quo = (nmag_reg > NW'(64'h8000_0000)) ? Q_MIN : (32'd0 - nmag_reg[VAL_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

// File: sv/coupled_field_stencil_forces_core.sv
`timescale 1ns / 1ps
// Load: written in the cycle it is taken, block stays free. Compute: two site decode passes, a
// range and face check, reads of the center and six neighbor words, 41 multiplies on the shared
// multiplier and a serial divide of 32+FRAC_BITS shift steps, then the result strobe and free.
// Face or out-of-range sites go from the check straight to the result strobe with zero results.
// Results cannot be stalled by the receiver.
// Reset returns control registers to idle and config registers to their defaults; the site store is not cleared.
module coupled_field_stencil_forces_core #(
    parameter int GRID_N    = cfsf_pkg::DEF_GRID_N,
    parameter int FRAC_BITS = cfsf_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [cfsf_pkg::SITE_W-1:0]   site,
    input  cfsf_pkg::q_t                  s_comp0,
    input  cfsf_pkg::q_t                  s_comp1,
    input  cfsf_pkg::q_t                  s_comp2,
    input  cfsf_pkg::q_t                  b_comp0,
    input  cfsf_pkg::q_t                  b_comp1,
    input  cfsf_pkg::q_t                  b_comp2,
    output logic                          result_valid,
    output cfsf_pkg::q_t                  acc_s0,
    output cfsf_pkg::q_t                  acc_s1,
    output cfsf_pkg::q_t                  acc_s2,
    output cfsf_pkg::q_t                  acc_b0,
    output cfsf_pkg::q_t                  acc_b1,
    output cfsf_pkg::q_t                  acc_b2,
    output logic                          saturated,
    input  logic                          cfg_wr,
    input  logic [cfsf_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [cfsf_pkg::VAL_W-1:0]    cfg_wdata
);
    import cfsf_pkg::*;

    localparam longint NSITES = longint'(GRID_N) * GRID_N * GRID_N;
    localparam int DEPTH = (NSITES < (64'd1 << SITE_W)) ? int'(NSITES) : (1 << SITE_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = SITE_W + 2;
    localparam int RW    = $clog2(GRID_N) + 1;
    localparam int NN    = GRID_N * GRID_N;

    // reciprocal of GRID_N, exact floor for every SITE_W-bit dividend
    localparam int DSH = SITE_W + $clog2(GRID_N);
    localparam int MW  = SITE_W + 2;
    localparam int PW  = DSH + SITE_W;
    localparam logic [MW-1:0] DMUL =
        MW'(((64'd1 << DSH) + 64'(GRID_N) - 64'd1) / 64'(GRID_N));

    localparam logic signed [63:0] Q_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [33:0] Q_ONE  = 34'sd1 <<< FRAC_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADIV  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIVS  = 3'd5;
    localparam logic [2:0] ST_DIVW  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // multiply sequence: shared terms first, then nine steps per component
    localparam logic [4:0] MS_P1  = 5'd0;
    localparam logic [4:0] MS_P2  = 5'd1;
    localparam logic [4:0] MS_PP  = 5'd2;
    localparam logic [4:0] MS_KD  = 5'd3;
    localparam logic [4:0] MS_NUM = 5'd4;
    localparam logic [4:0] MS_DD  = 5'd5;
    localparam logic [4:0] MS_S2A = 5'd6;
    localparam logic [4:0] MS_S2B = 5'd7;
    localparam logic [4:0] MS_S2C = 5'd8;
    localparam logic [4:0] MS_B2A = 5'd9;
    localparam logic [4:0] MS_B2B = 5'd10;
    localparam logic [4:0] MS_B2C = 5'd11;
    localparam logic [4:0] MS_CB  = 5'd12;
    localparam logic [4:0] MS_CS  = 5'd13;
    localparam logic [4:0] MS_LS  = 5'd14;
    localparam logic [4:0] MS_MS  = 5'd15;
    localparam logic [4:0] MS_T1  = 5'd16;
    localparam logic [4:0] MS_FT  = 5'd17;
    localparam logic [4:0] MS_FP  = 5'd18;
    localparam logic [4:0] MS_CBS = 5'd19;
    localparam logic [4:0] MS_LB  = 5'd20;
    localparam logic [4:0] MS_MB  = 5'd21;
    localparam logic [4:0] MS_CSB = 5'd22;

    // config
    q_t          mass_sq_reg, mu_reg, kappa_reg, pair_reg, cross_reg;
    logic [30:0] inv_dx2_reg;

    // control
    logic [2:0]     state_reg;
    logic [4:0]     step_reg;
    logic           ph_reg;
    logic [1:0]     a_reg;
    logic [2:0]     rd_cnt_reg;
    logic           rd_vld_reg;
    logic [2:0]     rd_idx_reg;
    logic           pass_reg;

    // datapath
    logic [SITE_W-1:0] site_reg, dvd_reg;
    logic              in_range_reg;
    logic [RW-1:0]     k_reg, j_reg;
    logic [XW-1:0]     ip_reg, im_reg, jp_reg, jm_reg, kp_reg, km_reg;
    q_t                s0_reg, s1_reg, s2_reg, b0_reg, b1_reg, b2_reg;
    logic signed [35:0] ls0_reg, ls1_reg, ls2_reg, lb0_reg, lb1_reg, lb2_reg;
    logic signed [63:0] prod_reg;
    q_t                t_p_reg, t_pp_reg, t_num_reg, t_dd_reg, t_cb2_reg, t_cs2_reg;
    q_t                t_tmp_reg, mpd_reg;
    logic signed [33:0] t_den_reg, s2acc_reg, b2acc_reg;
    logic signed [35:0] acc_s_reg, acc_b_reg;
    q_t                out_s0_reg, out_s1_reg, out_s2_reg, out_b0_reg, out_b1_reg, out_b2_reg;
    logic              sat_reg;

    logic accept, in_range_in;
    logic [PW-1:0]     dmul_prod;
    logic [SITE_W-1:0] dvd_new;
    logic [SITE_W-1:0] rem_full;
    logic [RW-1:0]     rem_new;
    logic              face;

    logic          mem_wr, mem_rd;
    logic [AW-1:0] mem_raddr;
    logic [XW-1:0] raddr_x;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    q_t f_s0, f_s1, f_s2, f_b0, f_b1, f_b2;

    q_t sa, sa1, sa2, ba, op_a, op_b, rw;
    logic signed [35:0] lsa, lba;
    logic signed [63:0] rnd;
    q_t fin_s, fin_b;

    logic div_done;
    q_t   div_quo;

    assign accept      = start && !busy;
    assign in_range_in = 64'(site) < NSITES;
    assign busy        = state_reg != ST_IDLE;

    // site decode: reciprocal multiply by GRID_N, one pass for k, one for j
    assign dmul_prod = PW'(dvd_reg) * PW'(DMUL);
    assign dvd_new   = dmul_prod[DSH +: SITE_W];
    assign rem_full  = dvd_reg - SITE_W'(dvd_new * SITE_W'(GRID_N));
    assign rem_new   = rem_full[RW-1:0];

    assign face = (dvd_reg == '0) || (dvd_reg >= SITE_W'(GRID_N - 1))
               || (j_reg == '0) || (j_reg >= RW'(GRID_N - 1));

    assign mem_wr    = accept && (cmd == CMD_LOAD) && in_range_in;
    assign mem_wdata = {b_comp2, b_comp1, b_comp0, s_comp2, s_comp1, s_comp0};
    assign mem_rd    = (state_reg == ST_READ) && (rd_cnt_reg != 3'd7);

    always_comb
    begin
        case (rd_cnt_reg)
            3'd0:    raddr_x = XW'(site_reg);
            3'd1:    raddr_x = ip_reg;
            3'd2:    raddr_x = im_reg;
            3'd3:    raddr_x = jp_reg;
            3'd4:    raddr_x = jm_reg;
            3'd5:    raddr_x = kp_reg;
            default: raddr_x = km_reg;
        endcase
    end
    assign mem_raddr = raddr_x[AW-1:0];

    assign f_s0 = mem_rdata[0*VAL_W +: VAL_W];
    assign f_s1 = mem_rdata[1*VAL_W +: VAL_W];
    assign f_s2 = mem_rdata[2*VAL_W +: VAL_W];
    assign f_b0 = mem_rdata[3*VAL_W +: VAL_W];
    assign f_b1 = mem_rdata[4*VAL_W +: VAL_W];
    assign f_b2 = mem_rdata[5*VAL_W +: VAL_W];

    cfsf_field_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (site[AW-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (mem_rd),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    cfsf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DIVS),
        .num   (t_num_reg),
        .den   (t_dd_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // component selection for the current component a and its two partners
    always_comb
    begin
        case (a_reg)
            2'd0:
            begin
                sa = s0_reg; sa1 = s1_reg; sa2 = s2_reg; ba = b0_reg;
                lsa = ls0_reg; lba = lb0_reg;
            end
            2'd1:
            begin
                sa = s1_reg; sa1 = s2_reg; sa2 = s0_reg; ba = b1_reg;
                lsa = ls1_reg; lba = lb1_reg;
            end
            default:
            begin
                sa = s2_reg; sa1 = s0_reg; sa2 = s1_reg; ba = b2_reg;
                lsa = ls2_reg; lba = lb2_reg;
            end
        endcase
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            MS_P1:  begin op_a = s0_reg;               op_b = s1_reg;               end
            MS_P2:  begin op_a = t_p_reg;              op_b = s2_reg;               end
            MS_PP:  begin op_a = t_p_reg;              op_b = t_p_reg;              end
            MS_KD:  begin op_a = kappa_reg;            op_b = t_pp_reg;             end
            MS_NUM: begin op_a = mu_reg;               op_b = t_p_reg;              end
            MS_DD:  begin op_a = clip32(64'(t_den_reg)); op_b = clip32(64'(t_den_reg)); end
            MS_S2A: begin op_a = s0_reg;               op_b = s0_reg;               end
            MS_S2B: begin op_a = s1_reg;               op_b = s1_reg;               end
            MS_S2C: begin op_a = s2_reg;               op_b = s2_reg;               end
            MS_B2A: begin op_a = b0_reg;               op_b = b0_reg;               end
            MS_B2B: begin op_a = b1_reg;               op_b = b1_reg;               end
            MS_B2C: begin op_a = b2_reg;               op_b = b2_reg;               end
            MS_CB:  begin op_a = cross_reg;            op_b = clip32(64'(b2acc_reg)); end
            MS_CS:  begin op_a = cross_reg;            op_b = clip32(64'(s2acc_reg)); end
            MS_LS:  begin op_a = clip32(64'(lsa));     op_b = {1'b0, inv_dx2_reg};  end
            MS_MS:  begin op_a = mass_sq_reg;          op_b = sa;                   end
            MS_T1:  begin op_a = sa1;                  op_b = sa2;                  end
            MS_FT:  begin op_a = mpd_reg;              op_b = t_tmp_reg;            end
            MS_FP:  begin op_a = pair_reg;             op_b = clip32(64'(sa1) + 64'(sa2)); end
            MS_CBS: begin op_a = t_cb2_reg;            op_b = sa;                   end
            MS_LB:  begin op_a = clip32(64'(lba));     op_b = {1'b0, inv_dx2_reg};  end
            MS_MB:  begin op_a = mass_sq_reg;          op_b = ba;                   end
            MS_CSB: begin op_a = t_cs2_reg;            op_b = ba;                   end
            default: begin op_a = '0;                  op_b = '0;                   end
        endcase
    end

    // round half up: add half an LSB, floor shift, saturate
    assign rnd   = (prod_reg + Q_HALF) >>> FRAC_BITS;
    assign rw    = clip32(rnd);
    assign fin_s = clip32(64'(acc_s_reg));
    assign fin_b = clip32(64'(acc_b_reg - 36'(rw)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_sq_reg <= 32'sd37748736;
            mu_reg      <= '0;
            kappa_reg   <= '0;
            pair_reg    <= '0;
            cross_reg   <= 32'sd167772;
            inv_dx2_reg <= 31'd16777216;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_addr)
                CFG_MASS_SQ:    mass_sq_reg <= cfg_wdata;
                CFG_TRIPLE_MU:  mu_reg      <= cfg_wdata;
                CFG_TRIPLE_KAP: kappa_reg   <= cfg_wdata;
                CFG_PAIR_GAIN:  pair_reg    <= cfg_wdata;
                CFG_CROSS_GAIN: cross_reg   <= cfg_wdata;
                CFG_INV_DX2:    inv_dx2_reg <= cfg_wdata[30:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= MS_P1;
            ph_reg     <= 1'b0;
            a_reg      <= 2'd0;
            rd_cnt_reg <= 3'd0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= 3'd0;
            pass_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= mem_rd;
            rd_idx_reg <= rd_cnt_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cmd == CMD_COMPUTE))
                    begin
                        state_reg <= ST_ADIV;
                        pass_reg  <= 1'b0;
                    end
                end
                ST_ADIV:
                begin
                    pass_reg <= 1'b1;
                    if (pass_reg)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    rd_cnt_reg <= 3'd0;
                    state_reg  <= (!in_range_reg || face) ? ST_OUT : ST_READ;
                end
                ST_READ:
                begin
                    if (rd_cnt_reg != 3'd7)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                        step_reg  <= MS_P1;
                        ph_reg    <= 1'b0;
                    end
                end
                ST_MUL:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (step_reg == MS_CS)
                        begin
                            state_reg <= ST_DIVS;
                        end
                        else if (step_reg == MS_CSB)
                        begin
                            step_reg <= MS_LS;
                            if (a_reg == 2'd2)
                                state_reg <= ST_OUT;
                            else
                                a_reg <= a_reg + 1'b1;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                ST_DIVS:
                begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_MUL;
                        step_reg  <= MS_LS;
                        a_reg     <= 2'd0;
                        ph_reg    <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd == CMD_COMPUTE))
        begin
            site_reg     <= site;
            dvd_reg      <= site;
            in_range_reg <= in_range_in;
        end

        if (state_reg == ST_ADIV)
        begin
            dvd_reg <= dvd_new;
            if (pass_reg)
                j_reg <= rem_new;
            else
                k_reg <= rem_new;
        end

        if (state_reg == ST_CHECK)
        begin
            ip_reg <= XW'(site_reg) + XW'(NN);
            im_reg <= XW'(site_reg) - XW'(NN);
            jp_reg <= XW'(site_reg) + XW'(GRID_N);
            jm_reg <= XW'(site_reg) - XW'(GRID_N);
            // k wraps around the row
            kp_reg <= (k_reg == RW'(GRID_N - 1)) ? (XW'(site_reg) - XW'(k_reg))
                                                 : (XW'(site_reg) + XW'(1));
            km_reg <= (k_reg == '0) ? (XW'(site_reg) + XW'(GRID_N - 1))
                                    : (XW'(site_reg) - XW'(1));
            out_s0_reg <= '0; out_s1_reg <= '0; out_s2_reg <= '0;
            out_b0_reg <= '0; out_b1_reg <= '0; out_b2_reg <= '0;
            sat_reg    <= 1'b0;
        end

        // center word starts the sums at -6*c, neighbors add in
        if (rd_vld_reg)
        begin
            if (rd_idx_reg == 3'd0)
            begin
                s0_reg <= f_s0; s1_reg <= f_s1; s2_reg <= f_s2;
                b0_reg <= f_b0; b1_reg <= f_b1; b2_reg <= f_b2;
                ls0_reg <= 36'(f_s0) * 36'sd6 * -36'sd1;
                ls1_reg <= 36'(f_s1) * 36'sd6 * -36'sd1;
                ls2_reg <= 36'(f_s2) * 36'sd6 * -36'sd1;
                lb0_reg <= 36'(f_b0) * 36'sd6 * -36'sd1;
                lb1_reg <= 36'(f_b1) * 36'sd6 * -36'sd1;
                lb2_reg <= 36'(f_b2) * 36'sd6 * -36'sd1;
            end
            else
            begin
                ls0_reg <= ls0_reg + 36'(f_s0);
                ls1_reg <= ls1_reg + 36'(f_s1);
                ls2_reg <= ls2_reg + 36'(f_s2);
                lb0_reg <= lb0_reg + 36'(f_b0);
                lb1_reg <= lb1_reg + 36'(f_b1);
                lb2_reg <= lb2_reg + 36'(f_b2);
            end
        end

        if (state_reg == ST_DIVW && div_done)
        begin
            mpd_reg <= div_quo;
        end

        if (state_reg == ST_MUL)
        begin
            if (!ph_reg)
            begin
                prod_reg <= 64'(op_a) * 64'(op_b);
            end
            else
            begin
                case (step_reg)
                    MS_P1, MS_P2: t_p_reg   <= rw;
                    MS_PP:        t_pp_reg  <= rw;
                    MS_KD:        t_den_reg <= Q_ONE + 34'(rw);
                    MS_NUM:       t_num_reg <= rw;
                    MS_DD:        t_dd_reg  <= rw;
                    MS_S2A:       s2acc_reg <= 34'(rw);
                    MS_S2B, MS_S2C: s2acc_reg <= s2acc_reg + 34'(rw);
                    MS_B2A:       b2acc_reg <= 34'(rw);
                    MS_B2B, MS_B2C: b2acc_reg <= b2acc_reg + 34'(rw);
                    MS_CB:        t_cb2_reg <= rw;
                    MS_CS:        t_cs2_reg <= rw;
                    MS_LS:        acc_s_reg <= 36'(rw);
                    MS_MS, MS_FT, MS_FP, MS_CBS: acc_s_reg <= acc_s_reg - 36'(rw);
                    MS_T1:        t_tmp_reg <= rw;
                    MS_LB:        acc_b_reg <= 36'(rw);
                    MS_MB:        acc_b_reg <= acc_b_reg - 36'(rw);
                    MS_CSB:
                    begin
                        case (a_reg)
                            2'd0:    begin out_s0_reg <= fin_s; out_b0_reg <= fin_b; end
                            2'd1:    begin out_s1_reg <= fin_s; out_b1_reg <= fin_b; end
                            default: begin out_s2_reg <= fin_s; out_b2_reg <= fin_b; end
                        endcase
                        if ((36'(fin_s) != acc_s_reg)
                            || (36'(fin_b) != (acc_b_reg - 36'(rw))))
                            sat_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign result_valid = state_reg == ST_OUT;
    assign acc_s0       = out_s0_reg;
    assign acc_s1       = out_s1_reg;
    assign acc_s2       = out_s2_reg;
    assign acc_b0       = out_b0_reg;
    assign acc_b1       = out_b1_reg;
    assign acc_b2       = out_b2_reg;
    assign saturated    = sat_reg;

endmodule

// File: sv/cfsf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for coupled_field_stencil_forces_core, bound to the top level.
// Depends on the top level's port names and on cfsf_pkg.
module cfsf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic result_valid
);
    import cfsf_pkg::*;

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_LOAD) |=> !busy)
        else $error("load word made the core busy");

    a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_COMPUTE) |=> busy && !result_valid)
        else $error("compute word not taken up");

endmodule

bind coupled_field_stencil_forces_core cfsf_checker u_cfsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid)
);
